// ----- sv/bslp_pkg.sv -----
// Shared types and constants for the button short/long press detector.
// Used by bslp_step and button_short_long_press; depends on nothing.
`timescale 1ns / 1ps

package bslp_pkg;

  // Elapsed-tick counter width and configuration register width
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_W       = 16;
  localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG    = 2'd1;

  localparam logic [CFG_W-1:0] HOLDOFF_RESET = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RESET    = 16'd1000;

  // Phase codes
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_PRESS_HOLD = 3'd1;
  localparam logic [2:0] PH_PRESSED    = 3'd2;
  localparam logic [2:0] PH_WAIT_REL   = 3'd3;
  localparam logic [2:0] PH_REL_HOLD   = 3'd4;

  // Report codes
  localparam logic [1:0] REP_NONE  = 2'd0;
  localparam logic [1:0] REP_SET   = 2'd1;
  localparam logic [1:0] REP_CLEAR = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic [2:0]             phase;
    logic [COUNT_WIDTH-1:0] elapsed;
    logic                   short_seen;
    logic                   long_seen;
  } state_t;

  typedef struct packed {
    logic [1:0] short_report;
    logic [1:0] long_report;
  } report_t;

endpackage

// ----- sv/button_short_long_press.sv -----
// Button short/long press detector: input register, one-tick step logic,
// result register. Depends on bslp_pkg and bslp_step.
// Path: an accepted tick goes to the input register, then its result to the
// result register. Throughput: one tick per cycle unless out_ready holds the
// result register, set by the single phase update and compare in between.
// Reset: phase idle, counter and flags zero, hold-off 50 and long limit 1000.
`timescale 1ns / 1ps

module button_short_long_press (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           button_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           short_flag,
  output logic                           long_flag,
  output logic [1:0]                     short_report,
  output logic [1:0]                     long_report,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bslp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bslp_pkg::CFG_W-1:0]     cfg_data
);

  logic [bslp_pkg::CFG_W-1:0] holdoff;
  logic [bslp_pkg::CFG_W-1:0] long_limit;
  logic                       in_full;
  logic                       level_q;
  logic                       advance;
  bslp_pkg::state_t           state;
  bslp_pkg::state_t           state_next;
  bslp_pkg::report_t          report;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff    <= bslp_pkg::HOLDOFF_RESET;
      long_limit <= bslp_pkg::LONG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == bslp_pkg::REG_HOLDOFF) holdoff    <= cfg_data;
      if (cfg_index == bslp_pkg::REG_LONG)    long_limit <= cfg_data;
    end
  end

  // Input register: take a transfer whenever the slot is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) level_q <= button_level;
  end

  bslp_step u_step (
    .state      (state),
    .level      (level_q),
    .holdoff    (holdoff),
    .long_limit (long_limit),
    .state_next (state_next),
    .report     (report)
  );

  // Detector state advances once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= bslp_pkg::PH_IDLE;
      state.elapsed    <= '0;
      state.short_seen <= 1'b0;
      state.long_seen  <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      short_flag   <= state_next.short_seen;
      long_flag    <= state_next.long_seen;
      short_report <= report.short_report;
      long_report  <= report.long_report;
    end
  end

  // Both flags are never set within one press cycle
  assert property (@(posedge clk) disable iff (rst)
    !(state.short_seen && state.long_seen))
    else $error("short and long flags set together");

  // A set report always shows its flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (short_report == bslp_pkg::REP_SET) |-> short_flag)
    else $error("short set report without short flag");

  // A clear report comes on the tick that still shows the flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (long_report == bslp_pkg::REP_CLEAR) |-> long_flag)
    else $error("long clear report without long flag");

  // State moves only when a tick passes to the result register
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("detector state changed without a tick");

endmodule

// ----- sv/bslp_step.sv -----
// Next-state and report logic for one tick of the press detector.
// Depends on bslp_pkg for the state struct, phase and report codes.
`timescale 1ns / 1ps

module bslp_step (
  input  bslp_pkg::state_t             state,
  input  logic                         level,
  input  logic [bslp_pkg::CFG_W-1:0]   holdoff,
  input  logic [bslp_pkg::CFG_W-1:0]   long_limit,
  output bslp_pkg::state_t             state_next,
  output bslp_pkg::report_t            report
);

  logic [bslp_pkg::COUNT_WIDTH-1:0] elapsed_inc;
  logic [bslp_pkg::CMP_W-1:0]       elapsed_cmp;
  logic [bslp_pkg::CMP_W-1:0]       holdoff_cmp;
  logic [bslp_pkg::CMP_W-1:0]       long_cmp;
  logic                             holdoff_done;
  logic                             past_long;

  // Saturating tick count, then compare at a common width
  assign elapsed_inc  = (state.elapsed != bslp_pkg::COUNT_MAX) ?
                        state.elapsed + bslp_pkg::COUNT_WIDTH'(1) : state.elapsed;
  assign elapsed_cmp  = bslp_pkg::CMP_W'(elapsed_inc);
  assign holdoff_cmp  = bslp_pkg::CMP_W'(holdoff);
  assign long_cmp     = bslp_pkg::CMP_W'(long_limit);
  assign holdoff_done = elapsed_cmp > holdoff_cmp;
  assign past_long    = elapsed_cmp > long_cmp;

  // Phase transitions
  always_comb begin
    state_next         = state;
    state_next.elapsed = elapsed_inc;
    report.short_report = bslp_pkg::REP_NONE;
    report.long_report  = bslp_pkg::REP_NONE;
    case (state.phase)
      bslp_pkg::PH_IDLE: begin
        state_next.short_seen = 1'b0;
        state_next.long_seen  = 1'b0;
        if (level) begin
          state_next.elapsed = '0;
          state_next.phase   = bslp_pkg::PH_PRESS_HOLD;
        end
      end
      bslp_pkg::PH_PRESS_HOLD: begin
        if (holdoff_done) begin
          state_next.phase = level ? bslp_pkg::PH_PRESSED : bslp_pkg::PH_IDLE;
        end
      end
      bslp_pkg::PH_PRESSED: begin
        if (!level) begin
          // A release beyond the long limit is ignored
          if (!past_long) begin
            state_next.short_seen = 1'b1;
            report.short_report   = bslp_pkg::REP_SET;
            state_next.elapsed    = '0;
            state_next.phase      = bslp_pkg::PH_REL_HOLD;
          end
        end else if (past_long) begin
          state_next.long_seen = 1'b1;
          report.long_report   = bslp_pkg::REP_SET;
          state_next.phase     = bslp_pkg::PH_WAIT_REL;
        end
      end
      bslp_pkg::PH_WAIT_REL: begin
        if (!level) begin
          state_next.elapsed = '0;
          state_next.phase   = bslp_pkg::PH_REL_HOLD;
        end
      end
      bslp_pkg::PH_REL_HOLD: begin
        if (holdoff_done) begin
          if (state.short_seen) report.short_report = bslp_pkg::REP_CLEAR;
          if (state.long_seen)  report.long_report  = bslp_pkg::REP_CLEAR;
          state_next.phase = bslp_pkg::PH_IDLE;
        end
      end
      default: begin
        state_next.phase = bslp_pkg::PH_IDLE;
      end
    endcase
  end

endmodule
